// ----- src/owtr_pkg.sv -----
package owtr_pkg;

  localparam int unsigned NumRegs  = 8;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned RegDataW = 10;

  // register indexes
  localparam logic [RegIdxW-1:0] RegResetLow   = 3'd0;
  localparam logic [RegIdxW-1:0] RegResetRel   = 3'd1;
  localparam logic [RegIdxW-1:0] RegPresTo     = 3'd2;
  localparam logic [RegIdxW-1:0] RegRelTo      = 3'd3;
  localparam logic [RegIdxW-1:0] RegShort      = 3'd4;
  localparam logic [RegIdxW-1:0] RegLong       = 3'd5;
  localparam logic [RegIdxW-1:0] RegSample     = 3'd6;
  localparam logic [RegIdxW-1:0] RegTail       = 3'd7;

  // command codes
  localparam logic [1:0] ModeNone     = 2'd0;
  localparam logic [1:0] ModePresence = 2'd1;
  localparam logic [1:0] ModeRead     = 2'd2;

  // status codes
  localparam logic [1:0] StatOk        = 2'd0;
  localparam logic [1:0] StatNoPres    = 2'd1;
  localparam logic [1:0] StatNoRelease = 2'd2;

  // bus commands
  localparam logic [7:0] CmdSkipRom = 8'hCC;
  localparam logic [7:0] CmdConvert = 8'h44;
  localparam logic [7:0] CmdReadPad = 8'hBE;

  typedef struct packed {
    logic [9:0] reset_low_us;
    logic [5:0] reset_release_us;
    logic [7:0] presence_timeout_us;
    logic [7:0] release_timeout_us;
    logic [3:0] short_pulse_us;
    logic [6:0] long_slot_us;
    logic [5:0] sample_delay_us;
    logic [6:0] read_tail_us;
  } cfg_t;

  typedef struct packed {
    logic               drive_low;
    logic               busy_res;
    logic               done_res;
    logic [1:0]         status;
    logic signed [15:0] temperature;
  } result_t;

  typedef enum logic [9:0] {
    PhIdle     = 10'b00_0000_0001,
    PhRstLow   = 10'b00_0000_0010,
    PhRstRel   = 10'b00_0000_0100,
    PhPresWait = 10'b00_0000_1000,
    PhPresEnd  = 10'b00_0001_0000,
    PhWLow     = 10'b00_0010_0000,
    PhWHigh    = 10'b00_0100_0000,
    PhRLow     = 10'b00_1000_0000,
    PhRWait    = 10'b01_0000_0000,
    PhRTail    = 10'b10_0000_0000
  } phase_e;

  function automatic logic [7:0] script_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = CmdSkipRom;
      2'd1:    b = CmdConvert;
      2'd2:    b = CmdSkipRom;
      default: b = CmdReadPad;
    endcase
    return b;
  endfunction

endpackage

// ----- src/one_wire_temperature_reader_unit.sv -----
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tdata: mode, line_level
// m_axis    out  m_axis_tvalid/tready      tdata: drive_low .. temperature
// cfg       in   cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
//
// one item per cycle sustained while m_axis_tready is high; an item passes from input
// to output through the input register, then one state update into the output register
// the sequencer state advances only when an item moves into the output register
// a stalled output holds its item while one more item waits in the input register
// reset returns the sequencer to idle and the timing registers to their defaults
module one_wire_temperature_reader_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // mode[1:0], line_level[2]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // drive_low[0], busy_res[1], done_res[2], status[4:3], temperature[20:5]
  output logic [23:0]                   m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [owtr_pkg::RegIdxW-1:0]  cfg_index_i,
  input  logic [owtr_pkg::RegDataW-1:0] cfg_data_i
);
  import owtr_pkg::*;

  logic       in_valid_q, in_valid_d;
  logic [1:0] mode_q;
  logic       line_q;
  logic       out_valid_q, out_valid_d;
  result_t    res_q, res;
  cfg_t       cfg;
  logic       step;

  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;
  assign in_valid_d    = s_axis_tvalid ? 1'b1 : (in_valid_q && !step);
  assign out_valid_d   = step ? 1'b1 : (out_valid_q && !m_axis_tready);

  owtr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  owtr_fsm u_fsm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .mode_i       (mode_q),
    .line_level_i (line_q),
    .cfg_i        (cfg),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= in_valid_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      mode_q <= s_axis_tdata[1:0];
      line_q <= s_axis_tdata[2];
    end
    if (step) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, res_q.temperature, res_q.status, res_q.done_res,
                          res_q.busy_res, res_q.drive_low};

endmodule

// ----- src/owtr_cfg.sv -----
module owtr_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [owtr_pkg::RegIdxW-1:0]   cfg_index_i,
  input  logic [owtr_pkg::RegDataW-1:0]  cfg_data_i,
  output owtr_pkg::cfg_t                 cfg_o
);
  import owtr_pkg::*;

  cfg_t regs_q, regs_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = regs_q;

  always_comb begin
    regs_d = regs_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegResetLow: regs_d.reset_low_us        = cfg_data_i;
        RegResetRel: regs_d.reset_release_us    = cfg_data_i[5:0];
        RegPresTo:   regs_d.presence_timeout_us = cfg_data_i[7:0];
        RegRelTo:    regs_d.release_timeout_us  = cfg_data_i[7:0];
        RegShort:    regs_d.short_pulse_us      = cfg_data_i[3:0];
        RegLong:     regs_d.long_slot_us        = cfg_data_i[6:0];
        RegSample:   regs_d.sample_delay_us     = cfg_data_i[5:0];
        RegTail:     regs_d.read_tail_us        = cfg_data_i[6:0];
        default:     regs_d = regs_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.reset_low_us        <= 10'd750;
      regs_q.reset_release_us    <= 6'd15;
      regs_q.presence_timeout_us <= 8'd200;
      regs_q.release_timeout_us  <= 8'd240;
      regs_q.short_pulse_us      <= 4'd2;
      regs_q.long_slot_us        <= 7'd60;
      regs_q.sample_delay_us     <= 6'd12;
      regs_q.read_tail_us        <= 7'd50;
    end else begin
      regs_q <= regs_d;
    end
  end

endmodule

// ----- src/owtr_fsm.sv -----
module owtr_fsm (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [1:0]        mode_i,
  input  logic              line_level_i,
  input  owtr_pkg::cfg_t    cfg_i,
  output owtr_pkg::result_t res_o
);
  import owtr_pkg::*;

  phase_e      phase_q, phase_d;
  logic [9:0]  tick_q, tick_d;
  logic [2:0]  bit_q, bit_d;
  logic [2:0]  byte_q, byte_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  low_q, low_d;
  logic [15:0] reading_q, reading_d;
  logic [1:0]  status_q, status_d;
  logic        kind_q, kind_d;
  logic        done;

  logic [9:0]  tick_inc;
  logic [9:0]  dur;
  logic        expired;
  logic        one;
  logic [2:0]  bit_inc;

  assign tick_inc = tick_q + 10'd1;
  assign one      = shift_q[0];
  assign bit_inc  = bit_q + 3'd1;
  assign expired  = tick_inc >= dur;

  // duration of the current phase
  always_comb begin
    unique case (phase_q)
      PhRstLow:   dur = cfg_i.reset_low_us;
      PhRstRel:   dur = 10'(cfg_i.reset_release_us);
      PhPresWait: dur = 10'(cfg_i.presence_timeout_us);
      PhPresEnd:  dur = 10'(cfg_i.release_timeout_us);
      PhWLow:     dur = one ? 10'(cfg_i.short_pulse_us) : 10'(cfg_i.long_slot_us);
      PhWHigh:    dur = one ? 10'(cfg_i.long_slot_us) : 10'(cfg_i.short_pulse_us);
      PhRLow:     dur = 10'(cfg_i.short_pulse_us);
      PhRWait:    dur = 10'(cfg_i.sample_delay_us);
      PhRTail:    dur = 10'(cfg_i.read_tail_us);
      default:    dur = 10'd1;
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    tick_d    = tick_q;
    bit_d     = bit_q;
    byte_d    = byte_q;
    shift_d   = shift_q;
    low_d     = low_q;
    reading_d = reading_q;
    status_d  = status_q;
    kind_d    = kind_q;
    done      = 1'b0;

    unique case (phase_q)
      PhIdle: begin
        if (mode_i == ModePresence || mode_i == ModeRead) begin
          kind_d   = (mode_i == ModeRead);
          status_d = StatOk;
          byte_d   = 3'd0;
          bit_d    = 3'd0;
          phase_d  = PhRstLow;
          tick_d   = 10'd0;
        end
      end
      PhRstLow, PhRstRel, PhWLow, PhRLow: begin
        tick_d = tick_inc;
        if (expired) begin
          tick_d = 10'd0;
          unique case (phase_q)
            PhRstLow: phase_d = PhRstRel;
            PhRstRel: phase_d = PhPresWait;
            PhWLow:   phase_d = PhWHigh;
            default:  phase_d = PhRWait;
          endcase
        end
      end
      PhPresWait, PhPresEnd: begin
        if (phase_q == PhPresWait && !line_level_i) begin
          phase_d = PhPresEnd;
          tick_d  = 10'd0;
        end else if (phase_q == PhPresEnd && line_level_i) begin
          tick_d = 10'd0;
        end else begin
          tick_d = tick_inc;
          if (expired && status_q == StatOk) begin
            status_d = (phase_q == PhPresWait) ? StatNoPres : StatNoRelease;
          end
        end
        // presence step over: either finish or start sending the script
        if ((phase_q == PhPresEnd && line_level_i) ||
            (expired && !(phase_q == PhPresWait && !line_level_i))) begin
          tick_d = 10'd0;
          if (!kind_q) begin
            phase_d = PhIdle;
            done    = 1'b1;
          end else begin
            shift_d = script_byte(byte_q[1:0]);
            bit_d   = 3'd0;
            phase_d = PhWLow;
          end
        end
      end
      PhWHigh: begin
        tick_d = tick_inc;
        if (expired) begin
          tick_d  = 10'd0;
          shift_d = {1'b0, shift_q[7:1]};
          bit_d   = bit_inc;
          if (bit_inc != 3'd0) begin
            phase_d = PhWLow;
          end else if (byte_q == 3'd1) begin
            byte_d  = 3'd2;
            phase_d = PhRstLow;
          end else if (byte_q >= 3'd3) begin
            byte_d  = 3'd4;
            shift_d = 8'd0;
            phase_d = PhRLow;
          end else begin
            byte_d  = byte_q + 3'd1;
            shift_d = script_byte(2'(byte_q + 3'd1));
            phase_d = PhWLow;
          end
        end
      end
      PhRWait: begin
        tick_d = tick_inc;
        if (expired) begin
          tick_d  = 10'd0;
          shift_d = {line_level_i, shift_q[7:1]};
          phase_d = PhRTail;
        end
      end
      PhRTail: begin
        tick_d = tick_inc;
        if (expired) begin
          tick_d = 10'd0;
          bit_d  = bit_inc;
          if (bit_inc != 3'd0) begin
            phase_d = PhRLow;
          end else if (byte_q == 3'd4) begin
            low_d   = shift_q;
            byte_d  = 3'd5;
            shift_d = 8'd0;
            phase_d = PhRLow;
          end else begin
            reading_d = {shift_q, low_q};
            phase_d   = PhIdle;
            done      = 1'b1;
          end
        end
      end
      default: begin
        phase_d = PhIdle;
        tick_d  = 10'd0;
      end
    endcase
  end

  assign res_o.drive_low   = (phase_d == PhRstLow) || (phase_d == PhWLow) ||
                             (phase_d == PhRLow);
  assign res_o.busy_res    = (phase_d != PhIdle);
  assign res_o.done_res    = done;
  assign res_o.status      = status_d;
  assign res_o.temperature = reading_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      tick_q    <= 10'd0;
      bit_q     <= 3'd0;
      byte_q    <= 3'd0;
      shift_q   <= 8'd0;
      low_q     <= 8'd0;
      reading_q <= 16'd0;
      status_q  <= StatOk;
      kind_q    <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      tick_q    <= tick_d;
      bit_q     <= bit_d;
      byte_q    <= byte_d;
      shift_q   <= shift_d;
      low_q     <= low_d;
      reading_q <= reading_d;
      status_q  <= status_d;
      kind_q    <= kind_d;
    end
  end

endmodule
